>>> hdl/nitr_pkg.sv
// Package: shared constants and types for the tie-rank block.
`timescale 1ns / 1ps
package nitr_pkg;
    localparam int MAX_LEN_DEF = 64;
    localparam int VAL_W       = 64;
    localparam int RANK_W      = 8;

    typedef enum logic [1:0] {
        RM_AVERAGE = 2'd0,
        RM_MIN     = 2'd1,
        RM_MAX     = 2'd2,
        RM_FIRST   = 2'd3
    } t_rank_method;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_EMIT  = 2'd2
    } t_back_state;

    // Request passed from the front part to the back part.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             present;
        logic             last;
    } t_req;
endpackage

>>> hdl/nitr_front.sv
// Front part: accepts input requests and queues them for the back part.
`timescale 1ns / 1ps
module nitr_front
    import nitr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [VAL_W-1:0] i_sample_value,
    input  logic             i_sample_present,
    input  logic             i_series_end,
    output logic             o_q_valid,
    output t_req             o_q_req,
    input  logic             i_q_take
);
    // Two-entry queue.
    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_mem[r_rp];

    // Write incoming request.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{value: i_sample_value, present: i_sample_present,
                             last: i_series_end};
        end
    end

    // Advance pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_take};
        end
    end

`ifndef SYNTHESIS
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_take |-> o_q_valid) else $error("take from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_q_take) |=> o_stall) else $error("full queue not stalled");
`endif
endmodule

>>> hdl/nitr_back.sv
// Back part: stores the series, ranks each position by a scan, emits results.
`timescale 1ns / 1ps
module nitr_back
    import nitr_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_method,
    input  logic              i_q_valid,
    input  t_req              i_q_req,
    output logic              o_q_take,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RANK_W-1:0] o_rank_twice,
    output logic              o_rank_present,
    output logic              o_capacity_exceeded,
    output logic              o_final_rank
);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [VAL_W-1:0] r_vmem [MAX_LEN];
    logic             r_pmem [MAX_LEN];

    t_back_state r_st, n_st;
    logic [CW-1:0] r_cnt, r_n;
    logic          r_ovf;
    logic [IW-1:0] r_pos, r_j;
    logic [VAL_W-1:0] r_v;      // value of position under ranking
    logic             r_vp;
    logic [VAL_W-1:0] r_rv;     // registered read of scanned entry
    logic             r_rp;
    logic             r_rd_ok;  // r_rv holds a valid entry
    logic [IW-1:0]    r_rj;
    logic             r_rlast;
    logic [CW-1:0] r_less, r_eq, r_bef;
    logic             r_ov;     // output register valid
    logic [RANK_W-1:0] r_rank;
    logic              r_rpres, r_ocap, r_ofin;
    logic              w_store, w_load_take, w_lt, w_eq, w_fire;
    logic [RANK_W:0]   w_rank;

    assign w_load_take = (r_st == ST_LOAD) && i_q_valid;
    assign o_q_take    = w_load_take;
    assign w_store     = w_load_take && (r_cnt < CW'(MAX_LEN));
    assign w_lt = $signed(r_rv) < $signed(r_v);
    assign w_eq = r_rv == r_v;
    // Rank finished when the last scanned compare lands and output is free.
    assign w_fire = (r_st == ST_EMIT) && (!r_ov || !i_stall);

    // Store writes.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_vmem[r_cnt[IW-1:0]] <= i_q_req.value;
            r_pmem[r_cnt[IW-1:0]] <= i_q_req.present;
        end
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_LOAD: if (w_load_take && i_q_req.last) n_st = ST_SCAN;
            ST_SCAN: if (r_rd_ok && r_rlast) n_st = ST_EMIT;
            ST_EMIT: if (w_fire) n_st = (r_pos == IW'(r_n - 1'b1)) ? ST_LOAD : ST_SCAN;
            default: n_st = ST_LOAD;
        endcase
    end

    // Rank from counts.
    always_comb begin
        case (i_method)
            RM_MIN:   w_rank = (RANK_W+1)'(2 * (r_less + 1));
            RM_MAX:   w_rank = (RANK_W+1)'(2 * (r_less + r_eq));
            RM_FIRST: w_rank = (RANK_W+1)'(2 * (r_less + r_bef + 1));
            default:  w_rank = (RANK_W+1)'(r_less + 1 + r_less + r_eq);
        endcase
    end

    // Read port: sweep entries during a scan; fetch the ranked position first.
    always_ff @(posedge i_clk) begin
        r_rv  <= r_vmem[r_j];
        r_rp  <= r_pmem[r_j];
        r_rj  <= r_j;
        r_rlast <= (r_j == IW'(r_n - 1'b1));
        if (r_st == ST_SCAN && !r_rd_ok) begin
            r_v  <= r_vmem[r_pos];
            r_vp <= r_pmem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_LOAD; r_cnt <= '0; r_ovf <= 1'b0; r_ov <= 1'b0;
            r_pos <= '0; r_j <= '0; r_rd_ok <= 1'b0; r_n <= '0;
            r_less <= '0; r_eq <= '0; r_bef <= '0;
        end else begin
            r_st <= n_st;
            // Load the result register, or drop it once taken.
            if (w_fire) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                ST_LOAD: begin
                    r_pos <= '0; r_j <= '0; r_rd_ok <= 1'b0;
                    r_less <= '0; r_eq <= '0; r_bef <= '0;
                    if (w_load_take) begin
                        if (w_store) r_cnt <= r_cnt + 1'b1;
                        else r_ovf <= 1'b1;
                        if (i_q_req.last) begin
                            r_n <= w_store ? r_cnt + 1'b1 : r_cnt;
                            // Empty series cannot occur: an end always stores or is full.
                        end
                    end
                end
                ST_SCAN: begin
                    r_rd_ok <= !(r_rd_ok && r_rlast);
                    if (r_j != IW'(r_n - 1'b1)) r_j <= r_j + 1'b1;
                    if (r_rd_ok && r_rp) begin
                        if (w_lt) r_less <= r_less + 1'b1;
                        else if (w_eq) begin
                            r_eq <= r_eq + 1'b1;
                            if (r_rj < r_pos) r_bef <= r_bef + 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_fire) begin
                        r_rank  <= r_vp ? w_rank[RANK_W-1:0] : '0;
                        r_rpres <= r_vp;
                        r_ocap  <= r_ovf;
                        r_ofin  <= (r_pos == IW'(r_n - 1'b1));
                        r_pos   <= r_pos + 1'b1;
                        r_j <= '0; r_less <= '0; r_eq <= '0; r_bef <= '0;
                        if (r_pos == IW'(r_n - 1'b1)) begin
                            r_cnt <= '0; r_ovf <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid             = r_ov;
    assign o_rank_twice        = r_rank;
    assign o_rank_present      = r_rpres;
    assign o_capacity_exceeded = r_ocap;
    assign o_final_rank        = r_ofin;

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_LEN)) else $error("store count over capacity");
    a_take_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_take |-> r_st == ST_LOAD) else $error("take outside load");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_rank))) else $error("result lost");
`endif
endmodule

>>> hdl/nullable_int64_tie_rank.sv
// Top level: null-aware tie ranking of a signed 64-bit series.
//  channel | signals                                     | direction
//  cfg     | i_cfg_we, i_cfg_data                        | in
//  sample  | i_valid/o_stall, value, present, series_end | in
//  rank    | o_valid/i_stall, rank_twice, flags          | out
// Loading accepts one sample per cycle through a two-entry queue while the queue is not full.
// After the end mark, each stored position is ranked by a scan of all n
// entries; the store is read at the scanned entry and at the ranked position.
// Reset (synchronous, active low) clears counts and method; the store holds no reset.
// Output stall holds the result register and pauses ranking.
`timescale 1ns / 1ps
module nullable_int64_tie_rank
    import nitr_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [VAL_W-1:0]  i_sample_value,
    input  logic              i_sample_present,
    input  logic              i_series_end,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RANK_W-1:0] o_rank_twice,
    output logic              o_rank_present,
    output logic              o_capacity_exceeded,
    output logic              o_final_rank
);
    logic [1:0] r_method;
    logic       w_qv, w_take;
    t_req       w_req;

    // Hold rank method register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_method <= RM_AVERAGE;
        else if (i_cfg_we) r_method <= i_cfg_data;
    end

    nitr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sample_value,
        .i_sample_present, .i_series_end,
        .o_q_valid(w_qv), .o_q_req(w_req), .i_q_take(w_take)
    );

    nitr_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk, .i_rst_n, .i_method(r_method),
        .i_q_valid(w_qv), .i_q_req(w_req), .o_q_take(w_take),
        .o_valid, .i_stall, .o_rank_twice, .o_rank_present,
        .o_capacity_exceeded, .o_final_rank
    );
endmodule
